### src/cdad_pkg.sv
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and calendar helpers
// Beat layouts for the date adder and the month and year length lookups
// ----------------------------------------------------------------------------
package cdad_pkg;

  typedef struct packed {
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [15:0] days_to_add;
  } in_item_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [8:0]  day_of_year;
    logic [8:0]  days_left;
    logic [4:0]  month_length;
    logic        leap;
    logic        bad_date;
  } out_item_t;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  localparam logic [8:0] YearCycle = 9'd400;
  localparam logic [8:0] CenturyA  = 9'd100;
  localparam logic [8:0] CenturyB  = 9'd200;
  localparam logic [8:0] CenturyC  = 9'd300;

  // leap test from the year taken modulo 400
  function automatic logic leap_of(input logic [8:0] r400);
    leap_of = (r400[1:0] == 2'd0) && (r400 != CenturyA) &&
              (r400 != CenturyB) && (r400 != CenturyC);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    case (m) inside
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      MonthFeb: len = lp ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    month_days = len;
  endfunction

  function automatic logic [8:0] year_days(input logic lp);
    year_days = lp ? 9'd366 : 9'd365;
  endfunction

endpackage

### src/calendar_date_add_days_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit: Gregorian date plus day count
// Iterative date adder built around one shared add/subtract unit
// ----------------------------------------------------------------------------
// Usage:
//   A beat on the input channel carries year, month, day and a day count.
//   in_stall_o is high from the accepting edge until the sequencer is done,
//   so one date is in flight at a time. The result beat carries the advanced
//   date plus the ordinal day, days left, month length and leap flag of the
//   input date, and a bad_date flag (then the date is echoed unchanged).
//   The sequencer reduces the year modulo 400, walks the months before the input
//   month (up to 11), works out the ordinal day and days left, adds the day
//   count, walks the years crossed, walks the months of the final year (up to
//   12), and loads the output register. The next date is taken at the earliest
//   in the cycle after the result is loaded.
//   Every step but the output load goes through the single shared adder.
//   The result waits in an output register; while out_stall_i holds it, the
//   next date is still taken and worked on, then waits before its own result.
//   Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit #(
  parameter int ADD_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cdad_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdad_pkg::out_item_t out_data_o
);

  import cdad_pkg::*;

  localparam int TW = ((ADD_WIDTH > 9) ? ADD_WIDTH : 9) + 1;
  localparam int UW = (TW > 15) ? TW : 15;
  localparam int AW = (ADD_WIDTH < 16) ? ADD_WIDTH : 16;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMod   = 3'd1;
  localparam logic [2:0] StDoy   = 3'd2;
  localparam logic [2:0] StLeft  = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StYear  = 3'd5;
  localparam logic [2:0] StMonth = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  logic [2:0]  state_q, state_d;
  in_item_t    in_q, in_d;
  logic [UW-1:0] total_q, total_d;
  logic [2:0]  k_q, k_d;
  logic [3:0]  mon_q, mon_d;
  logic [8:0]  r400_q, r400_d;
  logic [8:0]  ry_q, ry_d;
  logic [13:0] oy_q, oy_d;
  logic [8:0]  doy_q, doy_d;
  logic [8:0]  left_q, left_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [UW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_borrow;
  logic          alu_pos;

  logic          leap_in, leap_run, bad;
  logic [4:0]    mlen_in;

  cdad_addsub #(
    .W(UW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  // strictly greater: difference neither negative nor zero
  assign alu_pos = !alu_borrow && (alu_res != '0);

  assign leap_in  = leap_of(r400_q);
  assign leap_run = leap_of(ry_q);
  assign mlen_in  = month_days(in_q.in_month, leap_in);
  assign bad      = (in_q.in_month == 4'd0) || (in_q.in_month > MonthDec) ||
                    (in_q.in_day == 5'd0) || (in_q.in_day > mlen_in);

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    total_d     = total_q;
    k_d         = k_q;
    mon_d       = mon_q;
    r400_d      = r400_q;
    ry_d        = ry_q;
    oy_d        = oy_q;
    doy_d       = doy_q;
    left_d      = left_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    alu_a       = total_q;
    alu_b       = '0;
    alu_sub     = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          total_d = UW'(in_data_i.in_year);
          k_d     = 3'd5;
          state_d = StMod;
        end
      end
      // restoring reduction of the year by 400 << k
      StMod: begin
        alu_b = UW'(YearCycle) << k_q;
        if (!alu_borrow) begin
          total_d = alu_res;
        end
        k_d = k_q - 3'd1;
        if (k_q == 3'd0) begin
          r400_d  = alu_borrow ? total_q[8:0] : alu_res[8:0];
          total_d = UW'(in_q.in_day);
          mon_d   = 4'd1;
          state_d = StDoy;
        end
      end
      StDoy: begin
        alu_sub = 1'b0;
        alu_b   = UW'(month_days(mon_q, leap_in));
        if (bad) begin
          state_d = StFin;
        end else if (mon_q < in_q.in_month) begin
          total_d = alu_res;
          mon_d   = mon_q + 4'd1;
        end else begin
          state_d = StLeft;
        end
      end
      StLeft: begin
        alu_a   = UW'(year_days(leap_in));
        alu_b   = total_q;
        doy_d   = total_q[8:0];
        left_d  = alu_res[8:0];
        state_d = StAdd;
      end
      StAdd: begin
        alu_sub = 1'b0;
        alu_b   = UW'(in_q.days_to_add[AW-1:0]);
        total_d = alu_res;
        ry_d    = r400_q;
        oy_d    = in_q.in_year;
        state_d = StYear;
      end
      StYear: begin
        alu_b = UW'(year_days(leap_run));
        if (alu_pos) begin
          total_d = alu_res;
          oy_d    = oy_q + 14'd1;
          ry_d    = (ry_q == YearCycle - 9'd1) ? 9'd0 : ry_q + 9'd1;
        end else begin
          mon_d   = 4'd1;
          state_d = StMonth;
        end
      end
      StMonth: begin
        alu_b = UW'(month_days(mon_q, leap_run));
        if (mon_q < MonthDec && alu_pos) begin
          total_d = alu_res;
          mon_d   = mon_q + 4'd1;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.month_length = mlen_in;
          out_d.leap         = leap_in;
          out_d.bad_date     = bad;
          if (bad) begin
            out_d.out_year    = in_q.in_year;
            out_d.out_month   = in_q.in_month;
            out_d.out_day     = in_q.in_day;
            out_d.day_of_year = '0;
            out_d.days_left   = '0;
          end else begin
            out_d.out_year    = oy_q;
            out_d.out_month   = mon_q;
            out_d.out_day     = total_q[4:0];
            out_d.day_of_year = doy_q;
            out_d.days_left   = left_q;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    total_q <= total_d;
    k_q     <= k_d;
    mon_q   <= mon_d;
    r400_q  <= r400_d;
    ry_q    <= ry_d;
    oy_q    <= oy_d;
    doy_q   <= doy_d;
    left_q  <= left_d;
    out_q   <= out_d;
  end

endmodule

### src/cdad_addsub.sv
// ----------------------------------------------------------------------------
// cdad_addsub: shared add/subtract unit
// Single adder used for each arithmetic step of the date sequencer, with borrow out
// ----------------------------------------------------------------------------
module cdad_addsub #(
  parameter int W = 17
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         borrow_o
);

  logic [W:0] sum;

  always_comb begin
    if (sub_i) begin
      sum = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o    = sum[W-1:0];
  assign borrow_o = sub_i & sum[W];

endmodule

### tb/calendar_date_add_days_check.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days_check: result predictor and comparator
// Watches both channels of the date adder. Every accepted input beat is turned
// into the result it must give, and each accepted result beat is compared
// field by field with the oldest result still owed.
// ----------------------------------------------------------------------------
module calendar_date_add_days_check #(
  parameter int ADD_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cdad_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cdad_pkg::out_item_t out_data_i,
  output int                  errors_o,
  output int                  owed_o
);
  import cdad_pkg::*;

  out_item_t owed_dates[$];
  out_item_t want;
  int        errors = 0;
  int        owed = 0;

  assign errors_o = errors;
  assign owed_o   = owed;

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned len_of_month(int unsigned m, int unsigned y);
    case (m) inside
      MonthApr, MonthJun, MonthSep, MonthNov: return 30;
      MonthFeb: return is_leap(y) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned len_of_year(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic out_item_t advance_date(in_item_t beat);
    int unsigned y, m, d, add, mlen, doy, total, oy, om;
    bit bad;
    out_item_t r;
    y    = 32'(beat.in_year);
    m    = 32'(beat.in_month);
    d    = 32'(beat.in_day);
    add  = 32'(beat.days_to_add) & ((32'd1 << ADD_WIDTH) - 32'd1);
    mlen = len_of_month(m, y);
    bad  = (m < 1) || (m > MonthDec) || (d < 1) || (d > mlen);
    // a bad date is echoed with no ordinal or remainder
    r.out_year     = beat.in_year;
    r.out_month    = beat.in_month;
    r.out_day      = beat.in_day;
    r.day_of_year  = '0;
    r.days_left    = '0;
    r.month_length = mlen[4:0];
    r.leap         = is_leap(y);
    r.bad_date     = bad;
    if (!bad) begin
      doy = d;
      for (int unsigned i = 1; i < m; i++) doy += len_of_month(i, y);
      r.day_of_year = doy[8:0];
      r.days_left   = 9'(len_of_year(y) - doy);
      // walk whole years first; the year may run past 14 bits and wraps on output
      total = doy + add;
      oy    = y;
      while (total > len_of_year(oy)) begin
        total -= len_of_year(oy);
        oy++;
      end
      om = 1;
      while (om < MonthDec && total > len_of_month(om, oy)) begin
        total -= len_of_month(om, oy);
        om++;
      end
      r.out_year  = oy[13:0];
      r.out_month = om[3:0];
      r.out_day   = total[4:0];
    end
    return r;
  endfunction

  task automatic note_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic match_field(string name, int unsigned got, int unsigned exp_val);
    if (got != exp_val)
      note_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // retire before taking the new beat so a result never matches its own input
      if (out_valid_i && !out_stall_i) begin
        if (owed_dates.size() == 0) begin
          note_mismatch("result beat with no date owed");
        end else begin
          want = owed_dates.pop_front();
          match_field("out_year", 32'(out_data_i.out_year), 32'(want.out_year));
          match_field("out_month", 32'(out_data_i.out_month), 32'(want.out_month));
          match_field("out_day", 32'(out_data_i.out_day), 32'(want.out_day));
          match_field("day_of_year", 32'(out_data_i.day_of_year),
                      32'(want.day_of_year));
          match_field("days_left", 32'(out_data_i.days_left), 32'(want.days_left));
          match_field("month_length", 32'(out_data_i.month_length),
                      32'(want.month_length));
          match_field("leap", 32'(out_data_i.leap), 32'(want.leap));
          match_field("bad_date", 32'(out_data_i.bad_date), 32'(want.bad_date));
        end
      end
      if (in_valid_i && !in_stall_i) owed_dates.push_back(advance_date(in_data_i));
      owed = owed_dates.size();
    end
  end

endmodule

### tb/calendar_date_add_days_unit_tb.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit_tb: stimulus and verdict for the date adder
// Sends a directed set of calendar corner dates, then random dates that are
// mostly well formed with some malformed ones, with random idling on both
// channels, a long output hold-off and drain pauses. Checking is done by the
// checker module beside the block.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit_tb;
  import cdad_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int          RandomDates = 1300;
  localparam int          QuietFrom   = 1150;
  localparam int          HoldCycles  = 1500;
  localparam int          TailCycles  = 250;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int          mismatches;
  int          owed;
  int          dates_sent = 0;
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_add_days_unit #(
    .ADD_WIDTH(16)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  calendar_date_add_days_check #(
    .ADD_WIDTH(16)
  ) i_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (mismatches),
    .owed_o     (owed)
  );

  function automatic in_item_t date_beat(int unsigned y, int unsigned m, int unsigned d,
                                         int unsigned add);
    in_item_t b;
    b.in_year     = 14'(y);
    b.in_month    = 4'(m);
    b.in_day      = 5'(d);
    b.days_to_add = 16'(add);
    return b;
  endfunction

  // holds the beat until taken; valid stays high unless an idle burst follows
  task automatic send_date(input in_item_t beat);
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dates_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_dates();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (owed == 0);
  endtask

  // output side: random stall bursts, one long hold-off to back up the block
  initial begin
    bit          held;
    bit          st;
    int unsigned dur;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (quiet) begin
        st  = 1'b0;
        dur = 1;
      end else if (!held && dates_sent >= 60) begin
        st   = 1'b1;
        dur  = HoldCycles;
        held = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        st  = 1'b1;
        dur = $urandom_range(1, 16);
      end else begin
        st  = 1'b0;
        dur = $urandom_range(1, 24);
      end
      out_stall <= st;
      repeat (dur) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_item_t    corner[$];
    in_item_t    beat;
    int unsigned y, m, d, mlen, pick;
    bit          lp;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    corner.push_back(date_beat(1900, 1, 1, 0));
    corner.push_back(date_beat(9999, 12, 31, 65535));
    corner.push_back(date_beat(0, 2, 29, 1));          // year zero counts as leap
    corner.push_back(date_beat(16383, 12, 31, 65535)); // year wraps past 14 bits
    corner.push_back(date_beat(2000, 2, 29, 365));
    corner.push_back(date_beat(1900, 2, 29, 10));      // century without leap day
    corner.push_back(date_beat(2024, 0, 15, 5));
    corner.push_back(date_beat(2024, 13, 1, 5));
    corner.push_back(date_beat(2024, 15, 31, 65535));
    corner.push_back(date_beat(2023, 4, 31, 1));
    corner.push_back(date_beat(2023, 6, 0, 1));
    corner.push_back(date_beat(2023, 12, 31, 1));
    corner.push_back(date_beat(2023, 2, 28, 1));
    corner.push_back(date_beat(2024, 2, 28, 1));
    corner.push_back(date_beat(2100, 2, 28, 1));
    corner.push_back(date_beat(2400, 2, 28, 1));
    corner.push_back(date_beat(2023, 1, 31, 29));
    corner.push_back(date_beat(1999, 12, 31, 366));
    corner.push_back(date_beat(2024, 12, 31, 0));
    corner.push_back(date_beat(1900, 1, 1, 65535));
    corner.push_back(date_beat(2023, 2, 29, 0));
    corner.push_back(date_beat(9999, 1, 1, 0));
    corner.push_back(date_beat(2024, 3, 1, 0));
    corner.push_back(date_beat(0, 0, 0, 0));
    corner.push_back(date_beat(16383, 15, 31, 65535));
    foreach (corner[i]) send_date(corner[i]);
    drain_dates();

    for (int i = 0; i < RandomDates; i++) begin
      quiet = (i >= QuietFrom);
      if (i == RandomDates / 2) drain_dates();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        beat = date_beat($urandom_range(0, 16383), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom_range(0, 65535));
      end else begin
        case ($urandom_range(0, 9))
          0: y = $urandom_range(0, 16383);
          1, 2: y = $urandom_range(19, 99) * 100 + $urandom_range(0, 4);
          default: y = $urandom_range(1900, 9999);
        endcase
        m    = $urandom_range(1, 12);
        lp   = leap_of(9'(y % 400));
        mlen = 32'(month_days(4'(m), lp));
        if (pick < 18) begin
          // day past the month end, or day zero
          d = (mlen == 31) ? 0 : $urandom_range(mlen + 1, 31);
        end else if ($urandom_range(0, 4) == 0) begin
          d = mlen;
        end else begin
          d = $urandom_range(1, mlen);
        end
        case ($urandom_range(0, 3))
          0: beat = date_beat(y, m, d, $urandom_range(0, 31));
          1: beat = date_beat(y, m, d, $urandom_range(0, 400));
          2: beat = date_beat(y, m, d, $urandom_range(0, 4000));
          default: beat = date_beat(y, m, d, $urandom_range(0, 65535));
        endcase
      end
      send_date(beat);
    end

    drain_dates();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
src/cdad_pkg.sv
src/cdad_addsub.sv
src/calendar_date_add_days_unit.sv
tb/calendar_date_add_days_check.sv
tb/calendar_date_add_days_unit_tb.sv
